// File: hdl/srw_pkg.sv
// Shared types and constants of the selective-repeat receive window.
package srw_pkg;

	localparam int SEQ_BITS       = 16;
	localparam int TAG_BITS       = 32;
	localparam int LEN_BITS       = 13;
	localparam int WIN_CFG_BITS   = 4;
	localparam int WIN_CFG_RESET  = 8;
	localparam int MAX_WINDOW_DEF = 8;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef logic [SEQ_BITS-1:0] seq_t;

	typedef struct packed {
		seq_t                seq_number;
		logic                is_end;
		logic [TAG_BITS-1:0] payload_tag;
		logic [LEN_BITS-1:0] payload_len;
	} srw_item_t;

	typedef struct packed {
		logic                result_kind;
		seq_t                out_seq;
		logic [TAG_BITS-1:0] out_tag;
		logic [LEN_BITS-1:0] out_len;
		logic                transfer_done;
		logic                last_of_run;
	} srw_result_t;

	typedef struct packed {
		logic [TAG_BITS-1:0] tag;
		logic [LEN_BITS-1:0] len;
	} srw_slot_t;

	typedef struct packed {
		logic write;    // store the request payload in this cell
		logic start;    // reload the head token across the row
		logic hit;      // this cell is the head when the token reloads
		logic deliver;  // hand the head token to the next cell
	} srw_cell_ctrl_t;

endpackage

// File: hdl/srw_cell.sv
// One window slot: fill flag, stored payload and the head token.
module srw_cell import srw_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  srw_cell_ctrl_t ctrl,
	input  srw_slot_t      wr_data,
	input  logic           token_in,
	output logic           filled,
	output logic           token,
	output srw_slot_t      rd_data
);

	logic      filled_q;
	logic      token_q;
	srw_slot_t payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
			token_q  <= 1'b0;
		end else begin
			if (ctrl.write) begin
				filled_q <= 1'b1;
			end else if (ctrl.deliver && token_q) begin
				filled_q <= 1'b0;
			end
			if (ctrl.start) begin
				token_q <= ctrl.hit;
			end else if (ctrl.deliver) begin
				token_q <= token_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.write) begin
			payload_q <= wr_data;
		end
	end

	assign filled  = filled_q;
	assign token   = token_q;
	assign rd_data = payload_q;

endmodule

// File: hdl/selective_repeat_receive_window.sv
// Top level of the selective-repeat receive window: sequencer and row of slot cells.
//
// A request is taken on a clock edge with start high and busy low. It is
// latched, classified in the next cycle, and then either dropped (neither
// in the window nor at most the window size below the base, or beyond the
// end packet), acknowledged at once (below the base by at most the window
// size), or stored. For a stored request the head slot is first brought
// below the window size by subtract steps, needed only if the window was
// shrunk; the request is then written into its slot cell, the head token
// is loaded into the cell at the base, and the token then walks along the
// row one cell per cycle, delivering each filled slot in order. Each result
// is shown on result for exactly one cycle with result_valid high; the
// receiver cannot stall, so results are never held back. A run stops at
// the first empty slot, at the end packet, or after as many deliveries as
// the window size. The walk of the head token through the cells sets the
// delivery rate of one per cycle.
// The ack of a request is always its last result and carries last_of_run.
// Write the window size only while busy is low and no result is pending.
module selective_repeat_receive_window import srw_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  srw_item_t               item,
	output logic                    result_valid,
	output srw_result_t             result,
	input  logic                    cfg_we,
	input  logic [WIN_CFG_BITS-1:0] cfg_wdata
);

	localparam int WW    = $clog2(MAX_WINDOW + 1);
	localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SW    = WW + 1;
	localparam int W_RST = (MAX_WINDOW < WIN_CFG_RESET) ? MAX_WINDOW : WIN_CFG_RESET;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_NORM  = 3'd2;
	localparam logic [2:0] ST_STORE = 3'd3;
	localparam logic [2:0] ST_DELIV = 3'd4;
	localparam logic [2:0] ST_ACK   = 3'd5;

	logic [2:0]    state_q;
	logic [WW-1:0] w_q;
	logic [WW-1:0] w_cfg;
	srw_item_t     item_q;
	seq_t          base_q;
	seq_t          end_seq_q;
	logic          end_seen_q;
	logic          done_flag_q;
	logic [IW-1:0] head_slot_q;
	logic [IW-1:0] h_q;
	logic [WW-1:0] off_q;
	logic [IW-1:0] pos_q;
	logic [WW-1:0] cnt_q;
	srw_result_t   result_q;
	logic          result_valid_q;

	srw_cell_ctrl_t        ctrl [MAX_WINDOW];
	srw_slot_t             rd_data [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] filled;
	logic [MAX_WINDOW-1:0] token;
	logic [MAX_WINDOW-1:0] token_in;

	seq_t          off;
	seq_t          back;
	seq_t          end_off;
	logic          in_window;
	logic          beyond;
	logic          back_ok;
	logic          h_big;
	logic [SW-1:0] sum;
	logic [IW-1:0] pos_n;
	logic [SW-1:0] h_inc;
	logic [IW-1:0] h_next;
	logic [WW-1:0] w_m1;
	logic          head_filled;
	srw_slot_t     head_data;
	logic          deliver_en;
	logic          done_hit;
	srw_slot_t     wr_payload;

	// Clamp the written window size into 1..MAX_WINDOW.
	always_comb begin
		if (cfg_wdata == '0) begin
			w_cfg = WW'(1);
		end else if (int'(cfg_wdata) > MAX_WINDOW) begin
			w_cfg = WW'(MAX_WINDOW);
		end else begin
			w_cfg = WW'(cfg_wdata);
		end
	end

	// Classify the latched request against base and end mark.
	assign off       = item_q.seq_number - base_q;
	assign back      = base_q - item_q.seq_number;
	assign end_off   = end_seq_q - base_q;
	assign in_window = !done_flag_q && (off < SEQ_BITS'(w_q));
	assign beyond    = end_seen_q && (off > end_off);
	assign back_ok   = (back != '0) && (back <= SEQ_BITS'(w_q));

	// Slot arithmetic: head reduction, target slot, next head.
	assign h_big  = SW'(h_q) >= SW'(w_q);
	assign sum    = SW'(h_q) + SW'(off_q);
	assign pos_n  = (sum >= SW'(w_q)) ? IW'(sum - SW'(w_q)) : IW'(sum);
	assign h_inc  = SW'(h_q) + SW'(1);
	assign h_next = (h_inc == SW'(w_q)) ? '0 : IW'(h_inc);
	assign w_m1   = w_q - WW'(1);

	// Token ring: the last cell in use feeds cell 0, cells past it get nothing.
	always_comb begin
		token_in    = '0;
		token_in[0] = token[IW'(w_m1)];
		for (int i = 1; i < MAX_WINDOW; i++) begin
			token_in[i] = token[i-1] && (i < int'(w_q));
		end
	end

	// Select the head cell by its token.
	always_comb begin
		head_data   = '0;
		head_filled = 1'b0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			if (token[i]) begin
				head_data   = head_data | rd_data[i];
				head_filled = head_filled | filled[i];
			end
		end
	end

	assign deliver_en = (state_q == ST_DELIV) && head_filled && (cnt_q != w_q);
	assign done_hit   = end_seen_q && (base_q == end_seq_q);
	assign wr_payload = '{tag: item_q.payload_tag, len: item_q.payload_len};

	for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
		always_comb begin
			ctrl[g].write   = (state_q == ST_STORE) && (pos_q == IW'(g));
			ctrl[g].start   = (state_q == ST_STORE);
			ctrl[g].hit     = (h_q == IW'(g));
			ctrl[g].deliver = deliver_en;
		end

		srw_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[g]),
			.wr_data  (wr_payload),
			.token_in (token_in[g]),
			.filled   (filled[g]),
			.token    (token[g]),
			.rd_data  (rd_data[g])
		);
	end

	// Control state of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			w_q            <= WW'(W_RST);
			base_q         <= '0;
			end_seen_q     <= 1'b0;
			end_seq_q      <= '0;
			done_flag_q    <= 1'b0;
			head_slot_q    <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				w_q <= w_cfg;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (in_window && !beyond) begin
						state_q <= ST_NORM;
					end else if (!in_window && back_ok) begin
						state_q <= ST_ACK;
					end else begin
						// drop: outside the window and not just below the base, or past the end packet
						state_q <= ST_IDLE;
					end
				end
				ST_NORM: begin
					if (!h_big) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (item_q.is_end) begin
						end_seen_q <= 1'b1;
						end_seq_q  <= item_q.seq_number;
					end
					cnt_q   <= '0;
					state_q <= ST_DELIV;
				end
				ST_DELIV: begin
					if (deliver_en) begin
						result_valid_q <= 1'b1;
						base_q         <= base_q + 1'b1;
						head_slot_q    <= h_next;
						cnt_q          <= cnt_q + 1'b1;
						if (done_hit) begin
							done_flag_q <= 1'b1;
							state_q     <= ST_ACK;
						end
					end else begin
						state_q <= ST_ACK;
					end
				end
				ST_ACK: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			ST_EVAL: begin
				h_q   <= head_slot_q;
				off_q <= WW'(off);
			end
			ST_NORM: begin
				if (h_big) begin
					h_q <= IW'(SW'(h_q) - SW'(w_q));
				end else begin
					pos_q <= pos_n;
				end
			end
			ST_DELIV: begin
				if (deliver_en) begin
					h_q      <= h_next;
					result_q <= '{
						result_kind:   KIND_DELIVER,
						out_seq:       base_q,
						out_tag:       head_data.tag,
						out_len:       head_data.len,
						transfer_done: done_flag_q | done_hit,
						last_of_run:   1'b0
					};
				end
			end
			ST_ACK: begin
				result_q <= '{
					result_kind:   KIND_ACK,
					out_seq:       item_q.seq_number,
					out_tag:       '0,
					out_len:       '0,
					transfer_done: done_flag_q,
					last_of_run:   1'b1
				};
			end
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DELIV |-> $onehot(token))
		else $error("head token is not held by exactly one cell");

	a_head_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STORE || state_q == ST_DELIV) |-> SW'(h_q) < SW'(w_q))
		else $error("head slot outside the window");

	a_no_store_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_flag_q |-> state_q != ST_STORE)
		else $error("slot written after the transfer finished");

	a_run_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DELIV |-> cnt_q <= w_q)
		else $error("delivery run longer than the window");

	a_ack_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		deliver_en |=> result_valid && result.result_kind == KIND_DELIVER
			&& !result.last_of_run)
		else $error("delivery not presented as a non-final result");
`endif

endmodule
